/* rtl/mstd_pkg.sv */
// shared types, constants and coil table for the stepper tone driver
package mstd_pkg;

	localparam int BRIDGES     = 4;
	localparam int BRIDGE_W    = 2;
	localparam int PERIOD_W    = 16;
	localparam int POS_W       = 16;
	localparam int COIL_W      = 4;
	localparam int COILS_W     = 16;
	localparam int VISIBLE     = (BRIDGES < 4) ? BRIDGES : 4;
	localparam int APB_DW      = 32;
	localparam int PADDR_W     = 3;
	localparam int TRAVEL_W    = 16;

	localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 16'd3000;

	// register indexes
	localparam logic [PADDR_W-3:0] REG_MAX_TRAVEL = '0;

	typedef enum logic [2:0] {
		FUNC_TICK         = 3'd0,
		FUNC_NOTE_ON      = 3'd1,
		FUNC_NOTE_OFF     = 3'd2,
		FUNC_RESET_BRIDGE = 3'd3,
		FUNC_RESET_ALL    = 3'd4,
		FUNC_HALT_ALL     = 3'd5
	} func_t;

	// per-bridge command decoded from one word
	typedef struct packed {
		logic                en;
		logic                tick;
		logic                set_period;
		logic                clr_period;
		logic                clr_position;
		logic [PERIOD_W-1:0] period;
	} bridge_ctl_t;

	// coil lines IN1..IN4 (bit0 is IN1) for phases 0..3
	function automatic logic [COIL_W-1:0] coil_of_phase(input logic [1:0] ph);
		logic [COIL_W-1:0] c;
		unique case (ph)
			2'd0: c = 4'h5;
			2'd1: c = 4'h6;
			2'd2: c = 4'hA;
			2'd3: c = 4'h9;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/mstd_if.sv */
// valid/ready channel interfaces for command and result words
interface mstd_req_if;
	import mstd_pkg::*;
	logic                valid;
	logic                ready;
	logic [2:0]          func;
	logic [BRIDGE_W-1:0] bridge;
	logic [PERIOD_W-1:0] note_period;

	modport source (output valid, output func, output bridge, output note_period,
		input ready);
	modport sink (input valid, input func, input bridge, input note_period,
		output ready);
endinterface

interface mstd_res_if;
	import mstd_pkg::*;
	logic               valid;
	logic               ready;
	logic [COILS_W-1:0] coils;
	logic [3:0]         stepped;

	modport source (output valid, output coils, output stepped, input ready);
	modport sink (input valid, input coils, input stepped, output ready);
endinterface

/* rtl/mstd_bridge.sv */
// one stepper bridge: period, tick counter, position, direction and phase
module mstd_bridge
	import mstd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  bridge_ctl_t         ctl,
	input  logic [TRAVEL_W-1:0] max_travel,
	output logic [COIL_W-1:0]   coils,
	output logic                stepped
);

	logic [PERIOD_W-1:0] period_q, period_d;
	logic [PERIOD_W-1:0] tick_count_q, tick_count_d;
	logic [POS_W-1:0]    position_q, position_d;
	logic                reverse_q, reverse_d;
	logic [1:0]          phase_q, phase_d;
	logic [COIL_W-1:0]   coil_q, coil_d;
	logic [PERIOD_W:0]   cnt;
	logic                rev_turn;

	always_comb begin
		period_d     = period_q;
		tick_count_d = tick_count_q;
		position_d   = position_q;
		reverse_d    = reverse_q;
		phase_d      = phase_q;
		coil_d       = coil_q;
		stepped      = 1'b0;
		cnt          = {1'b0, tick_count_q} + 17'd1;

		// direction turns at the travel limit and at home
		if (position_q >= max_travel) begin
			rev_turn = 1'b1;
		end else if (position_q == '0) begin
			rev_turn = 1'b0;
		end else begin
			rev_turn = reverse_q;
		end

		if (ctl.en) begin
			if (ctl.tick && period_q != '0) begin
				if (cnt >= {1'b0, period_q}) begin
					stepped      = 1'b1;
					tick_count_d = '0;
					reverse_d    = rev_turn;
					if (rev_turn) begin
						if (position_q != '0) position_d = position_q - 16'd1;
						phase_d = phase_q - 2'd1;
					end else begin
						if (position_q != '1) position_d = position_q + 16'd1;
						phase_d = phase_q + 2'd1;
					end
					coil_d = coil_of_phase(phase_d);
				end else begin
					tick_count_d = cnt[PERIOD_W-1:0];
				end
			end
			if (ctl.set_period)   period_d   = ctl.period;
			if (ctl.clr_period)   period_d   = '0;
			if (ctl.clr_position) position_d = '0;
		end
	end

	assign coils = coil_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= '0;
			tick_count_q <= '0;
			position_q   <= '0;
			reverse_q    <= 1'b0;
			phase_q      <= '0;
			coil_q       <= '0;
		end else begin
			period_q     <= period_d;
			tick_count_q <= tick_count_d;
			position_q   <= position_d;
			reverse_q    <= reverse_d;
			phase_q      <= phase_d;
			coil_q       <= coil_d;
		end
	end

endmodule

/* rtl/multi_stepper_tone_driver_unit.sv */
// top level of the four-bridge stepper tone driver
//
// usage:
//   req channel: one command word per handshake (func, bridge, note_period).
//     func: tick, note on, note off, reset bridge, reset all, halt all;
//     unused codes change nothing and just report the coils.
//   res channel: one result word per command: coils of every visible bridge
//     after the update, and a stepped mask that is nonzero only for ticks.
//   apb port: one register, max_travel at byte address 0 (reset 3000),
//     to be written only while the block is idle; the block does not enforce this.
// pipeline: an accepted word lands in the input stage; it is applied, and its
//   result registered and offered on res, when it moves on to the result register.
// throughput: one word per cycle while res is not held, set by the bridge update
//   that runs combinationally between the input stage and the result register.
// reset: all bridge state clears, max_travel returns to 3000, no result is
//   pending and req is ready.
// stall: when res is held, the result register keeps its word and the input
//   stage takes one more word; ready then drops until res is taken.
module multi_stepper_tone_driver_unit
	import mstd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	mstd_req_if.sink           req,
	mstd_res_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	// config register
	logic [TRAVEL_W-1:0] max_travel_q;
	logic                reg_hit;

	// input stage
	logic                valid_s1;
	logic [2:0]          func_s1;
	logic [BRIDGE_W-1:0] bridge_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic                advance_s1;

	// result register
	logic               valid_s2;
	logic [COILS_W-1:0] coils_s2;
	logic [3:0]         stepped_s2;

	func_t                    func;
	bridge_ctl_t              ctl [BRIDGES];
	logic [COIL_W-1:0]        bridge_coils [BRIDGES];
	logic [BRIDGES-1:0]       bridge_stepped;
	logic [COILS_W-1:0]       coils_d;
	logic [3:0]               stepped_d;

	// apb: always ready, write in the access phase
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_MAX_TRAVEL);
	assign prdata  = reg_hit ? APB_DW'(max_travel_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_travel_q <= TRAVEL_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_travel_q <= pwdata[TRAVEL_W-1:0];
		end
	end

	// handshake: the input stage moves on when the result register is free
	assign advance_s1 = !valid_s2 || res.ready;
	assign req.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1   <= req.func;
			bridge_s1 <= req.bridge;
			period_s1 <= req.note_period;
		end
	end

	// decode the staged word into one command per bridge
	assign func = func_t'(func_s1);

	always_comb begin
		for (int b = 0; b < BRIDGES; b++) begin
			ctl[b]        = '0;
			ctl[b].en     = valid_s1 && advance_s1;
			ctl[b].period = period_s1;
			unique case (func)
				FUNC_TICK:         ctl[b].tick = 1'b1;
				FUNC_NOTE_ON:      ctl[b].set_period = (int'(bridge_s1) == b);
				FUNC_NOTE_OFF:     ctl[b].clr_period = (int'(bridge_s1) == b);
				FUNC_RESET_BRIDGE: begin
					ctl[b].clr_period   = (int'(bridge_s1) == b);
					ctl[b].clr_position = (int'(bridge_s1) == b);
				end
				FUNC_RESET_ALL: begin
					ctl[b].clr_period   = 1'b1;
					ctl[b].clr_position = 1'b1;
				end
				FUNC_HALT_ALL:     ctl[b].clr_period = 1'b1;
				// unused codes leave every bridge alone
				default:           ctl[b].en = 1'b0;
			endcase
		end
	end

	for (genvar b = 0; b < BRIDGES; b++) begin : g_bridge
		mstd_bridge u_bridge (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[b]),
			.max_travel (max_travel_q),
			.coils      (bridge_coils[b]),
			.stepped    (bridge_stepped[b])
		);
	end

	// only the first four bridges show up in the result word
	always_comb begin
		coils_d   = '0;
		stepped_d = '0;
		for (int b = 0; b < VISIBLE; b++) begin
			coils_d[COIL_W*b +: COIL_W] = bridge_coils[b];
			stepped_d[b]                = bridge_stepped[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1) begin
			coils_s2   <= coils_d;
			stepped_s2 <= stepped_d;
		end
	end

	assign res.valid   = valid_s2;
	assign res.coils   = coils_s2;
	assign res.stepped = stepped_s2;

	// a word that is not a tick never reports a step
	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance_s1 && func_s1 != FUNC_TICK) |=> (res.stepped == '0))
		else $error("stepped set for a non-tick word");

	// back pressure only when both stages hold a word and res is stalled
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (valid_s1 && valid_s2 && !res.ready))
		else $error("req not ready without a full stall");

	// an applied word always yields a pending result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance_s1) |=> res.valid)
		else $error("applied word produced no result");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the four-bridge stepper tone driver
module tb
	import mstd_pkg::*;
();

	// generous watchdog, far above the slowest correct run
	localparam int CYCLE_LIMIT  = 200000;
	// margin for the input stage and result register to drain
	localparam int DRAIN_CYCLES = 4;
	// random command words per max_travel setting
	localparam int PHASE_WORDS  = 275;
	localparam int SETTINGS_N   = 6;

	// one expected result word
	typedef struct {
		logic [COILS_W-1:0] coils;
		logic [3:0]         stepped;
	} coil_word_t;

	// bridge predictor plus queue of the result words still owed by the block
	class tone_scoreboard;
		logic [TRAVEL_W-1:0] travel_limit;
		logic [PERIOD_W-1:0] period_of [BRIDGES];
		logic [PERIOD_W-1:0] ticks_of [BRIDGES];
		logic [POS_W-1:0]    pos_of [BRIDGES];
		bit                  reversed [BRIDGES];
		logic [1:0]          phase_of [BRIDGES];
		logic [COIL_W-1:0]   pattern_of [BRIDGES];
		coil_word_t          due_words [$];
		int                  failures;
		int                  checked;
		int                  steps_seen;

		function new();
			travel_limit = TRAVEL_RESET;
			for (int b = 0; b < BRIDGES; b++) begin
				period_of[b] = '0;
				ticks_of[b] = '0;
				pos_of[b] = '0;
				reversed[b] = 1'b0;
				phase_of[b] = '0;
				pattern_of[b] = '0;
			end
			failures = 0;
			checked = 0;
			steps_seen = 0;
		endfunction

		// coil lines IN1..IN4 for each full-step phase
		function logic [COIL_W-1:0] coils_for_phase(logic [1:0] ph);
			case (ph)
				2'd0: return 4'h5;
				2'd1: return 4'h6;
				2'd2: return 4'hA;
				default: return 4'h9;
			endcase
		endfunction

		// one full step: turn around at the travel limit or at zero, then move
		function void take_full_step(int b);
			if (pos_of[b] >= travel_limit)
				reversed[b] = 1'b1;
			else if (pos_of[b] == '0)
				reversed[b] = 1'b0;
			if (reversed[b]) begin
				// holds at zero instead of wrapping
				if (pos_of[b] != '0)
					pos_of[b] = pos_of[b] - POS_W'(1);
				phase_of[b] = phase_of[b] - 2'd1;
			end else begin
				if (pos_of[b] != '1)
					pos_of[b] = pos_of[b] + POS_W'(1);
				phase_of[b] = phase_of[b] + 2'd1;
			end
			pattern_of[b] = coils_for_phase(phase_of[b]);
		endfunction

		// apply one accepted command word and queue the result it owes
		function void note_word(logic [2:0] f, logic [BRIDGE_W-1:0] br,
				logic [PERIOD_W-1:0] np);
			coil_word_t      due;
			logic [PERIOD_W:0] next_count;
			due.coils = '0;
			due.stepped = '0;
			case (f)
				FUNC_TICK: begin
					for (int b = 0; b < BRIDGES; b++) begin
						if (period_of[b] != '0) begin
							next_count = {1'b0, ticks_of[b]} + (PERIOD_W+1)'(1);
							// count >= period, so a lowered period steps at once
							if (next_count >= {1'b0, period_of[b]}) begin
								take_full_step(b);
								ticks_of[b] = '0;
								if (b < VISIBLE)
									due.stepped[b] = 1'b1;
							end else begin
								ticks_of[b] = next_count[PERIOD_W-1:0];
							end
						end
					end
				end
				FUNC_NOTE_ON: begin
					if (br < BRIDGES)
						period_of[br] = np;
				end
				FUNC_NOTE_OFF: begin
					if (br < BRIDGES)
						period_of[br] = '0;
				end
				FUNC_RESET_BRIDGE: begin
					// tick count, phase, direction and coils are kept
					if (br < BRIDGES) begin
						period_of[br] = '0;
						pos_of[br] = '0;
					end
				end
				FUNC_RESET_ALL: begin
					for (int b = 0; b < BRIDGES; b++) begin
						period_of[b] = '0;
						pos_of[b] = '0;
					end
				end
				FUNC_HALT_ALL: begin
					for (int b = 0; b < BRIDGES; b++)
						period_of[b] = '0;
				end
				default: begin
					// unused codes only report the coils
				end
			endcase
			for (int b = 0; b < VISIBLE; b++)
				due.coils[4*b +: 4] = pattern_of[b];
			for (int b = 0; b < 4; b++)
				if (due.stepped[b])
					steps_seen++;
			due_words.push_back(due);
		endfunction

		// compare one accepted result word with the oldest expectation
		function void check_word(logic [COILS_W-1:0] coils, logic [3:0] stepped);
			coil_word_t due;
			if (due_words.size() == 0) begin
				failures++;
				$display("%0t: result word with none expected, coils %h stepped %b",
					$time, coils, stepped);
				return;
			end
			due = due_words.pop_front();
			checked++;
			if (coils !== due.coils) begin
				failures++;
				$display("%0t: coils mismatch, expected %h, got %h", $time, due.coils, coils);
			end
			if (stepped !== due.stepped) begin
				failures++;
				$display("%0t: stepped mismatch, expected %b, got %b", $time, due.stepped,
					stepped);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	mstd_req_if req_ch ();
	mstd_res_if res_ch ();

	tone_scoreboard sb;

	// percent of cycles in which the sender holds back or the receiver stalls
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count;
	int words_sent;
	int settings_written;

	multi_stepper_tone_driver_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: check on each handshake, then pick the next ready at random
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready)
				sb.check_word(res_ch.coils, res_ch.stepped);
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one command word, with random idle cycles ahead of it, and wait
	// for the handshake; valid stays high so back-to-back words need no gap
	task automatic send_word(input logic [2:0] f, input logic [BRIDGE_W-1:0] br,
			input logic [PERIOD_W-1:0] np);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.bridge <= br;
		req_ch.note_period <= np;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_word(f, br, np);
		words_sent++;
	endtask

	// mostly ticks and note-ons with short periods so bridges keep stepping;
	// stops, resets, halts and unused codes are sprinkled in as noise
	task automatic send_random_word();
		int                  pick;
		logic [2:0]          f;
		logic [BRIDGE_W-1:0] br;
		logic [PERIOD_W-1:0] np;
		pick = $urandom_range(99);
		br = BRIDGE_W'($urandom_range(3));
		np = PERIOD_W'($urandom);
		if (pick < 58) begin
			f = FUNC_TICK;
		end else if (pick < 82) begin
			f = FUNC_NOTE_ON;
			pick = $urandom_range(99);
			if (pick < 75)
				np = PERIOD_W'($urandom_range(0, 6));
			else if (pick < 92)
				np = PERIOD_W'($urandom_range(7, 40));
		end else if (pick < 89) begin
			f = FUNC_NOTE_OFF;
		end else if (pick < 94) begin
			f = FUNC_RESET_BRIDGE;
		end else if (pick < 96) begin
			f = FUNC_RESET_ALL;
		end else if (pick < 98) begin
			f = FUNC_HALT_ALL;
		end else begin
			f = 3'($urandom_range(6, 7));
		end
		send_word(f, br, np);
	endtask

	// stop offering words and let every owed result come back
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (sb.due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// apb write: setup cycle, then access cycle, register taken at its edge
	task automatic write_register(input logic [PADDR_W-3:0] idx,
			input logic [TRAVEL_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAX_TRAVEL)
			sb.travel_limit = value;
		settings_written++;
	endtask

	initial begin
		logic [TRAVEL_W-1:0] travel_set [SETTINGS_N];

		sb = new();
		cycle_count <= 0;
		words_sent = 0;
		settings_written = 0;
		send_idle_pct = 12;
		recv_idle_pct = 64;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_TICK;
		req_ch.bridge <= '0;
		req_ch.note_period <= '0;

		// small limits make bridges turn around; zero keeps them reversed,
		// the top value is never reached
		travel_set[0] = 16'd2;
		travel_set[1] = 16'd0;
		travel_set[2] = 16'hFFFF;
		travel_set[3] = 16'd1;
		travel_set[4] = TRAVEL_RESET;
		travel_set[5] = TRAVEL_W'($urandom_range(3, 50));

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset travel limit
		send_word(FUNC_NOTE_ON, 2'd0, 16'd1);
		send_word(FUNC_NOTE_ON, 2'd1, 16'd2);
		send_word(FUNC_NOTE_ON, 2'd2, 16'd3);
		send_word(FUNC_NOTE_ON, 2'd3, 16'hFFFF);
		repeat (4)
			send_word(FUNC_TICK, 2'd3, 16'hFFFF);
		// a zero period means the note is off
		send_word(FUNC_NOTE_ON, 2'd3, 16'd0);
		send_word(FUNC_NOTE_ON, 2'd2, 16'd20);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		// period dropped below the running count steps on the next tick
		send_word(FUNC_NOTE_ON, 2'd2, 16'd1);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		send_word(FUNC_NOTE_OFF, 2'd0, 16'hFFFF);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		send_word(FUNC_RESET_BRIDGE, 2'd1, 16'd0);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		send_word(FUNC_HALT_ALL, 2'd0, 16'd0);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		// unused codes leave everything alone
		send_word(3'd6, 2'd2, 16'h5A5A);
		send_word(3'd7, 2'd1, 16'hA5A5);
		send_word(FUNC_NOTE_ON, 2'd0, 16'd1);
		send_word(FUNC_TICK, 2'd0, 16'd0);
		send_word(FUNC_RESET_ALL, 2'd0, 16'd0);
		send_word(FUNC_TICK, 2'd0, 16'd0);

		// random part, one travel setting per phase, idling changes as we go
		for (int ph = 0; ph < SETTINGS_N; ph++) begin
			wait_idle();
			write_register(REG_MAX_TRAVEL, travel_set[ph]);
			if (ph < 2) begin
				send_idle_pct = 12;
				recv_idle_pct = 64;
			end else if (ph < 4) begin
				send_idle_pct = 64;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < PHASE_WORDS; n++)
				send_random_word();
		end

		wait_idle();
		if (sb.due_words.size() != 0) begin
			sb.failures++;
			$display("%0t: %0d result words never arrived", $time, sb.due_words.size());
		end

		$display("covered %0d command words over %0d max_travel settings", words_sent,
			settings_written + 1);
		$display("checked %0d result words with %0d bridge steps, %0d failures", sb.checked,
			sb.steps_seen, sb.failures);
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/mstd_pkg.sv
rtl/mstd_if.sv
rtl/mstd_bridge.sv
rtl/multi_stepper_tone_driver_unit.sv
tb/sv/tb.sv
